@@ design/cdt_pkg.sv @@
// Package for the hours-minutes-seconds countdown timer.
// Holds event, key, item and mode codes, register indexes and reset values.
// No dependencies.
package cdt_pkg;

	localparam int BlinkW = 8;
	localparam int DivStepW = $clog2(BlinkW);
	localparam int CfgIdxW = 1;
	localparam int TotalW = 17;
	localparam int HourW = 5;
	localparam int MinW = 6;

	localparam logic [1:0] ACT_KEY = 2'd0;
	localparam logic [1:0] ACT_SECOND = 2'd1;
	localparam logic [1:0] ACT_FAST = 2'd2;

	localparam logic [1:0] KEY_NONE = 2'd0;
	localparam logic [1:0] KEY_BACK = 2'd1;
	localparam logic [1:0] KEY_NEXT = 2'd2;
	localparam logic [1:0] KEY_ACTIVATE = 2'd3;

	localparam logic [2:0] ITEM_HOURS = 3'd0;
	localparam logic [2:0] ITEM_MINUTES = 3'd1;
	localparam logic [2:0] ITEM_SECONDS = 3'd2;
	localparam logic [2:0] ITEM_RUN = 3'd3;
	localparam logic [2:0] ITEM_CANCEL = 3'd4;

	localparam logic [CfgIdxW-1:0] REG_BLINK_LENGTH = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_BLINK_HALF = 1'b1;

	localparam logic [HourW-1:0] HourMax = 5'd23;
	localparam logic [MinW-1:0] MinMax = 6'd59;

	localparam int BlinkLenInit = 100;
	localparam int BlinkHalfInit = 20;
	localparam logic [BlinkW-1:0] BLINK_LEN_RESET = BlinkW'(BlinkLenInit);
	localparam logic [BlinkW-1:0] BLINK_HALF_RESET = BlinkW'(BlinkHalfInit);
	localparam logic BLINK_LEN_PAR_RESET = 1'((BlinkLenInit / BlinkHalfInit) % 2);
	localparam logic [BlinkW-1:0] BLINK_LEN_REM_RESET = BlinkW'(BlinkLenInit % BlinkHalfInit);

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RUNNING = 2'd1,
		MODE_PAUSED = 2'd2
	} mode_t;

	function automatic logic [TotalW-1:0] cdt_total(input logic [HourW-1:0] h,
			input logic [MinW-1:0] m, input logic [MinW-1:0] s);
		logic [TotalW-1:0] acc;
		acc = TotalW'(h) * TotalW'(3600) + TotalW'(m) * TotalW'(60) + TotalW'(s);
		return acc;
	endfunction

endpackage

@@ design/countdown_timer_hms.sv @@
// Event-driven hours-minutes-seconds countdown timer, top level.
// Depends on cdt_pkg for codes, reset values and the seconds total function.
//
// Usage: each transfer on the input channel (action, key) is one event: a key
// press, a one-second tick or a fast tick. Every event produces exactly one
// result on the output channel, registered, in the cycle after the input transfer.
// Throughput is one event per clock while the divider is idle; an event is
// taken while the previous result waits if the output register frees at that edge.
// If the receiver stalls, the result holds and in_ready drops until it is taken.
// The remaining time is kept as hours, minutes and seconds counters, so no
// division is needed on the output; the seconds total is formed from them.
// The cancel blink phase is tracked as quotient parity and remainder of the
// blink counter by the half period. After every configuration transfer a
// restoring divider recomputes these; in_ready and cfg_ready are low while it
// runs.
// Reset clears the preset and remaining time to zero, the mode to idle, the
// selection to hours, the alarm and blink counter, and loads blink_length 100 and
// blink_half_period 20; no item is accepted before the first edge after reset.
module countdown_timer_hms
	import cdt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [1:0]          key,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [TotalW-1:0]   remaining_seconds,
	output logic [HourW-1:0]    shown_hours,
	output logic [MinW-1:0]     shown_minutes,
	output logic [MinW-1:0]     shown_seconds,
	output logic [1:0]          run_mode,
	output logic [2:0]          selected_item,
	output logic                alarm_pending,
	output logic                buzzer_start,
	output logic                buzzer_stop,
	output logic                leave_page,
	output logic                cancel_highlight,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [BlinkW-1:0]   cfg_data
);

	logic [BlinkW-1:0] blink_len_q, blink_half_q;
	logic              len_par_q;
	logic [BlinkW-1:0] len_rem_q;

	logic [HourW-1:0]  pre_h_q, tl_h_q;
	logic [MinW-1:0]   pre_m_q, pre_s_q, tl_m_q, tl_s_q;
	mode_t             mode_q;
	logic [2:0]        sel_q;
	logic              alarm_q;
	logic [BlinkW-1:0] cnt_q, cnt_rem_q;
	logic              cnt_par_q;

	logic                div_busy_q;
	logic [DivStepW-1:0] div_step_q;
	logic [BlinkW-1:0]   len_dvd_q, cnt_dvd_q, len_wrem_q, cnt_wrem_q;
	logic [BlinkW:0]     len_sh, cnt_sh;
	logic                len_ge, cnt_ge;
	logic [BlinkW-1:0]   half_eff;

	logic              out_valid_q;
	logic [TotalW-1:0] out_total_q;
	logic [HourW-1:0]  out_h_q;
	logic [MinW-1:0]   out_m_q, out_s_q;
	mode_t             out_mode_q;
	logic [2:0]        out_sel_q;
	logic              out_alarm_q, out_start_q, out_stop_q, out_leave_q, out_hl_q;

	logic              in_take, cfg_take;
	logic [HourW-1:0]  n_pre_h, n_tl_h;
	logic [MinW-1:0]   n_pre_m, n_pre_s, n_tl_m, n_tl_s;
	mode_t             n_mode;
	logic [2:0]        n_sel;
	logic              n_alarm, n_start, n_stop, n_leave, n_hl;
	logic [BlinkW-1:0] n_cnt, n_cnt_rem;
	logic              n_cnt_par;
	logic              tl_zero, tl_one, pre_zero;

	assign half_eff = (blink_half_q == '0) ? BlinkW'(1) : blink_half_q;
	assign in_ready = !div_busy_q && (!out_valid_q || out_ready);
	assign cfg_ready = !div_busy_q;
	assign in_take = in_valid && in_ready;
	assign cfg_take = cfg_valid && cfg_ready;

	assign tl_zero = (tl_h_q == '0) && (tl_m_q == '0) && (tl_s_q == '0);
	assign tl_one = (tl_h_q == '0) && (tl_m_q == '0) && (tl_s_q == MinW'(1));
	assign pre_zero = (pre_h_q == '0) && (pre_m_q == '0) && (pre_s_q == '0);

	always_comb begin
		n_pre_h = pre_h_q;
		n_pre_m = pre_m_q;
		n_pre_s = pre_s_q;
		n_tl_h = tl_h_q;
		n_tl_m = tl_m_q;
		n_tl_s = tl_s_q;
		n_mode = mode_q;
		n_sel = sel_q;
		n_alarm = alarm_q;
		n_cnt = cnt_q;
		n_cnt_rem = cnt_rem_q;
		n_cnt_par = cnt_par_q;
		n_start = 1'b0;
		n_stop = 1'b0;
		n_leave = 1'b0;
		case (action)
			ACT_KEY: begin
				case (key)
					KEY_BACK: n_leave = 1'b1;
					KEY_NEXT: n_sel = (sel_q == ITEM_CANCEL) ? ITEM_HOURS : sel_q + 3'd1;
					KEY_ACTIVATE: begin
						case (sel_q)
							ITEM_HOURS: begin
								if (mode_q == MODE_IDLE) begin
									n_pre_h = (pre_h_q == HourMax) ? '0 : pre_h_q + HourW'(1);
									n_tl_h = n_pre_h;
									n_tl_m = pre_m_q;
									n_tl_s = pre_s_q;
								end
							end
							ITEM_MINUTES: begin
								if (mode_q == MODE_IDLE) begin
									n_pre_m = (pre_m_q == MinMax) ? '0 : pre_m_q + MinW'(1);
									n_tl_h = pre_h_q;
									n_tl_m = n_pre_m;
									n_tl_s = pre_s_q;
								end
							end
							ITEM_SECONDS: begin
								if (mode_q == MODE_IDLE) begin
									n_pre_s = (pre_s_q == MinMax) ? '0 : pre_s_q + MinW'(1);
									n_tl_h = pre_h_q;
									n_tl_m = pre_m_q;
									n_tl_s = n_pre_s;
								end
							end
							ITEM_RUN: begin
								if (mode_q == MODE_IDLE) begin
									n_tl_h = pre_h_q;
									n_tl_m = pre_m_q;
									n_tl_s = pre_s_q;
									if (!pre_zero) begin
										n_mode = MODE_RUNNING;
										n_alarm = 1'b0;
										n_stop = 1'b1;
									end
								end else if (mode_q == MODE_PAUSED) begin
									n_mode = MODE_RUNNING;
									n_alarm = 1'b0;
									n_stop = 1'b1;
								end else if (mode_q == MODE_RUNNING) begin
									n_mode = MODE_PAUSED;
								end
							end
							default: begin
								if (mode_q == MODE_RUNNING || mode_q == MODE_PAUSED ||
										(mode_q == MODE_IDLE && alarm_q)) begin
									n_stop = 1'b1;
									n_alarm = 1'b0;
									n_tl_h = pre_h_q;
									n_tl_m = pre_m_q;
									n_tl_s = pre_s_q;
									n_mode = MODE_IDLE;
									n_cnt = blink_len_q;
									n_cnt_par = len_par_q;
									n_cnt_rem = len_rem_q;
								end
							end
						endcase
					end
					default: ;
				endcase
			end
			ACT_SECOND: begin
				if (mode_q == MODE_RUNNING && !tl_zero) begin
					if (tl_s_q != '0) begin
						n_tl_s = tl_s_q - MinW'(1);
					end else begin
						n_tl_s = MinMax;
						if (tl_m_q != '0) begin
							n_tl_m = tl_m_q - MinW'(1);
						end else begin
							n_tl_m = MinMax;
							n_tl_h = tl_h_q - HourW'(1);
						end
					end
					if (tl_one) begin
						n_mode = MODE_IDLE;
						n_alarm = 1'b1;
						n_start = 1'b1;
					end
				end
			end
			ACT_FAST: begin
				if (cnt_q != '0) begin
					n_cnt = cnt_q - BlinkW'(1);
					if (cnt_rem_q == '0) begin
						n_cnt_rem = half_eff - BlinkW'(1);
						n_cnt_par = !cnt_par_q;
					end else begin
						n_cnt_rem = cnt_rem_q - BlinkW'(1);
					end
				end
			end
			default: ;
		endcase
		n_hl = (n_sel == ITEM_CANCEL) && ((n_cnt == '0) || !n_cnt_par);
	end

	assign len_sh = {len_wrem_q, len_dvd_q[BlinkW-1]};
	assign cnt_sh = {cnt_wrem_q, cnt_dvd_q[BlinkW-1]};
	assign len_ge = len_sh >= {1'b0, half_eff};
	assign cnt_ge = cnt_sh >= {1'b0, half_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_len_q <= BLINK_LEN_RESET;
			blink_half_q <= BLINK_HALF_RESET;
			len_par_q <= BLINK_LEN_PAR_RESET;
			len_rem_q <= BLINK_LEN_REM_RESET;
			pre_h_q <= '0;
			pre_m_q <= '0;
			pre_s_q <= '0;
			tl_h_q <= '0;
			tl_m_q <= '0;
			tl_s_q <= '0;
			mode_q <= MODE_IDLE;
			sel_q <= ITEM_HOURS;
			alarm_q <= 1'b0;
			cnt_q <= '0;
			cnt_rem_q <= '0;
			cnt_par_q <= 1'b0;
			div_busy_q <= 1'b0;
			div_step_q <= '0;
			len_dvd_q <= '0;
			cnt_dvd_q <= '0;
			len_wrem_q <= '0;
			cnt_wrem_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_take) begin
				if (cfg_index == REG_BLINK_LENGTH) begin
					blink_len_q <= cfg_data;
				end else begin
					blink_half_q <= cfg_data;
				end
				len_dvd_q <= (cfg_index == REG_BLINK_LENGTH) ? cfg_data : blink_len_q;
				cnt_dvd_q <= cnt_q;
				len_wrem_q <= '0;
				cnt_wrem_q <= '0;
				div_step_q <= '0;
				div_busy_q <= 1'b1;
			end else if (div_busy_q) begin
				len_dvd_q <= {len_dvd_q[BlinkW-2:0], 1'b0};
				cnt_dvd_q <= {cnt_dvd_q[BlinkW-2:0], 1'b0};
				len_wrem_q <= len_ge ? BlinkW'(len_sh - {1'b0, half_eff}) : BlinkW'(len_sh);
				cnt_wrem_q <= cnt_ge ? BlinkW'(cnt_sh - {1'b0, half_eff}) : BlinkW'(cnt_sh);
				div_step_q <= div_step_q + DivStepW'(1);
				if (div_step_q == DivStepW'(BlinkW - 1)) begin
					div_busy_q <= 1'b0;
					len_par_q <= len_ge;
					len_rem_q <= len_ge ? BlinkW'(len_sh - {1'b0, half_eff}) : BlinkW'(len_sh);
					cnt_par_q <= cnt_ge;
					cnt_rem_q <= cnt_ge ? BlinkW'(cnt_sh - {1'b0, half_eff}) : BlinkW'(cnt_sh);
				end
			end
			if (in_take) begin
				pre_h_q <= n_pre_h;
				pre_m_q <= n_pre_m;
				pre_s_q <= n_pre_s;
				tl_h_q <= n_tl_h;
				tl_m_q <= n_tl_m;
				tl_s_q <= n_tl_s;
				mode_q <= n_mode;
				sel_q <= n_sel;
				alarm_q <= n_alarm;
				cnt_q <= n_cnt;
				cnt_rem_q <= n_cnt_rem;
				cnt_par_q <= n_cnt_par;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			out_total_q <= cdt_total(n_tl_h, n_tl_m, n_tl_s);
			out_h_q <= n_tl_h;
			out_m_q <= n_tl_m;
			out_s_q <= n_tl_s;
			out_mode_q <= n_mode;
			out_sel_q <= n_sel;
			out_alarm_q <= n_alarm;
			out_start_q <= n_start;
			out_stop_q <= n_stop;
			out_leave_q <= n_leave;
			out_hl_q <= n_hl;
		end
	end

	assign out_valid = out_valid_q;
	assign remaining_seconds = out_total_q;
	assign shown_hours = out_h_q;
	assign shown_minutes = out_m_q;
	assign shown_seconds = out_s_q;
	assign run_mode = out_mode_q;
	assign selected_item = out_sel_q;
	assign alarm_pending = out_alarm_q;
	assign buzzer_start = out_start_q;
	assign buzzer_stop = out_stop_q;
	assign leave_page = out_leave_q;
	assign cancel_highlight = out_hl_q;

	a_total_matches_split: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> remaining_seconds == cdt_total(shown_hours, shown_minutes, shown_seconds))
		else $error("remaining time total disagrees with its split");

	a_no_take_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy_q |-> !in_ready && !cfg_ready)
		else $error("transfer allowed while the blink divider runs");

	a_buzzer_start_sets_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && buzzer_start) |-> alarm_pending && !buzzer_stop &&
			run_mode == MODE_IDLE)
		else $error("buzzer start without alarm in idle");

	a_highlight_on_cancel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cancel_highlight) |-> selected_item == ITEM_CANCEL)
		else $error("cancel highlight with another item selected");

endmodule
